[rtl/c_tok_pkg.sv]
// Shared types, pattern tables and codes for the C token classifier.
package c_tok_pkg;

    localparam int NPAT   = 45;
    localparam int NKW    = 32;
    localparam int NRELOP = 7;

    localparam int P_MAIN_PAREN = 32;
    localparam int P_MAIN       = 33;
    localparam int P_PRINTF     = 34;
    localparam int P_SCANF      = 35;
    localparam int P_RELOP      = 36;
    localparam int P_OPEN       = 43;
    localparam int P_CLOSE      = 44;

    localparam logic [1:0] K_EXACT    = 2'd0;
    localparam logic [1:0] K_PAREN    = 2'd1;
    localparam logic [1:0] K_OPTPAREN = 2'd2;
    localparam logic [1:0] K_PREFIX   = 2'd3;

    localparam logic [4:0] CLS_NONE     = 5'd0;
    localparam logic [4:0] CLS_KEYWORD  = 5'd1;
    localparam logic [4:0] CLS_MAIN     = 5'd2;
    localparam logic [4:0] CLS_PRINTF   = 5'd3;
    localparam logic [4:0] CLS_SCANF    = 5'd4;
    localparam logic [4:0] CLS_PAREN    = 5'd5;
    localparam logic [4:0] CLS_ARGWORD  = 5'd6;
    localparam logic [4:0] CLS_CLOSE    = 5'd7;
    localparam logic [4:0] CLS_RELOP    = 5'd8;
    localparam logic [4:0] CLS_MATH     = 5'd15;
    localparam logic [4:0] CLS_BRACE    = 5'd16;
    localparam logic [4:0] CLS_SEMI     = 5'd17;
    localparam logic [4:0] CLS_INT      = 5'd18;
    localparam logic [4:0] CLS_FLOAT    = 5'd19;
    localparam logic [4:0] CLS_DIGITVAR = 5'd20;
    localparam logic [4:0] CLS_IDENT    = 5'd21;

    localparam logic [2:0] TYPE_NONE   = 3'd0;
    localparam logic [2:0] TYPE_CHAR   = 3'd1;
    localparam logic [2:0] TYPE_DOUBLE = 3'd2;
    localparam logic [2:0] TYPE_FLOAT  = 3'd3;
    localparam logic [2:0] TYPE_INT    = 3'd4;
    localparam logic [2:0] TYPE_LONG   = 3'd5;

    localparam logic [4:0] KW_CHAR   = 5'd3;
    localparam logic [4:0] KW_DOUBLE = 5'd8;
    localparam logic [4:0] KW_FLOAT  = 5'd12;
    localparam logic [4:0] KW_INT    = 5'd16;
    localparam logic [4:0] KW_LONG   = 5'd17;

    localparam logic [2:0] NF_DIGIT = 3'b001;
    localparam logic [2:0] NF_DOT   = 3'b010;
    localparam logic [2:0] NF_OTHER = 3'b100;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_M      = 8'h6D;

    // Text right-justified: character i sits at byte (len - 1 - i).
    localparam logic [63:0] PAT_TXT [NPAT] = '{
        64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
        64'("continue"), 64'("default"), 64'("do"), 64'("double"), 64'("else"),
        64'("enum"), 64'("extern"), 64'("float"), 64'("for"), 64'("goto"),
        64'("if"), 64'("int"), 64'("long"), 64'("register"), 64'("return"),
        64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"), 64'("struct"),
        64'("switch"), 64'("typedef"), 64'("union"), 64'("unsigned"), 64'("void"),
        64'("volatile"), 64'("while"),
        64'("main("), 64'("main"), 64'("printf"), 64'("scanf"),
        64'("<"), 64'("<="), 64'(">"), 64'(">="), 64'("=="), 64'("="), 64'("!="),
        64'("("), 64'(")")
    };

    localparam logic [3:0] PAT_LEN [NPAT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4,
        4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6,
        4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
        4'd8, 4'd5,
        4'd5, 4'd4, 4'd6, 4'd5,
        4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2,
        4'd1, 4'd1
    };

    localparam logic [1:0] PAT_KIND [NPAT] = '{
        K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_PAREN,
        K_EXACT, K_PAREN, K_EXACT, K_EXACT, K_EXACT, K_PAREN, K_EXACT, K_PAREN,
        K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT,
        K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_PAREN,
        K_PREFIX, K_PREFIX, K_OPTPAREN, K_OPTPAREN,
        K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT, K_EXACT,
        K_EXACT, K_EXACT
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       word_end;
    } in_word_t;

    typedef struct packed {
        logic [4:0] token_class;
        logic [4:0] keyword_id;
        logic [2:0] declared_type;
        logic       record_symbol;
    } out_word_t;

    typedef struct packed {
        logic       in_call;
        logic [2:0] pending_type;
    } ctx_t;

    function automatic logic [2:0] kw_type(input logic [4:0] kid);
        logic [2:0] t;
        unique case (kid)
            KW_CHAR:   t = TYPE_CHAR;
            KW_DOUBLE: t = TYPE_DOUBLE;
            KW_FLOAT:  t = TYPE_FLOAT;
            KW_INT:    t = TYPE_INT;
            KW_LONG:   t = TYPE_LONG;
            default:   t = TYPE_NONE;
        endcase
        return t;
    endfunction

    function automatic logic is_kw_letter(input logic [7:0] c);
        logic r;
        unique case (c)
            8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h69,
            8'h6C, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/c_tok_match.sv]
// Per-character pattern match vector, position and number flag update.
module c_tok_match
    import c_tok_pkg::*;
#(
    parameter int MAX_WORD_LEN = 64,
    localparam int POS_W = $clog2(MAX_WORD_LEN + 1)
)
(
    input  logic [7:0]       char_code,
    input  logic [NPAT-1:0]  match_vector,
    input  logic [POS_W-1:0] char_position,
    input  logic [7:0]       first_char,
    input  logic [2:0]       number_flags,
    output logic [NPAT-1:0]  match_vector_next,
    output logic [NPAT-1:0]  hits,
    output logic [POS_W-1:0] char_position_next,
    output logic [7:0]       first_char_next,
    output logic [2:0]       number_flags_next
);

    logic [POS_W:0] pos_inc;

    assign pos_inc = {1'b0, char_position} + (POS_W+1)'(1);
    assign char_position_next = (pos_inc < (POS_W+1)'(MAX_WORD_LEN)) ?
                                pos_inc[POS_W-1:0] : POS_W'(MAX_WORD_LEN);
    assign first_char_next = (char_position == '0) ? char_code : first_char;

    always_comb
    begin
        if (char_code >= CH_ZERO && char_code <= CH_NINE)
            number_flags_next = number_flags | NF_DIGIT;
        else if (char_code == CH_DOT)
            number_flags_next = number_flags | NF_DOT;
        else
            number_flags_next = number_flags | NF_OTHER;
    end

    always_comb
    begin
        logic       keep;
        logic [5:0] sh;
        keep = 1'b0;
        sh   = '0;
        for (int k = 0; k < NPAT; k++)
        begin
            if (char_position < POS_W'(PAT_LEN[k]))
            begin
                sh   = {3'(PAT_LEN[k] - 4'd1 - {1'b0, char_position[2:0]}), 3'b000};
                keep = (char_code == PAT_TXT[k][sh +: 8]);
            end
            else if (char_position == POS_W'(PAT_LEN[k]))
                keep = (PAT_KIND[k] == K_PREFIX) ||
                       ((PAT_KIND[k] == K_PAREN || PAT_KIND[k] == K_OPTPAREN) &&
                        char_code == CH_LPAREN);
            else
                keep = (PAT_KIND[k] == K_PREFIX) || (PAT_KIND[k] == K_PAREN);
            match_vector_next[k] = match_vector[k] & keep;
            hits[k] = match_vector_next[k] &
                      (char_position_next >= POS_W'(PAT_LEN[k]));
        end
    end

endmodule

[rtl/c_tok_classify.sv]
// Word-end token class decision and call and pending type context.
module c_tok_classify
    import c_tok_pkg::*;
(
    input  logic [NPAT-1:0] hits,
    input  logic [7:0]      first_char,
    input  logic [2:0]      number_flags,
    input  ctx_t            ctx,
    output out_word_t       result,
    output ctx_t            ctx_next
);

    always_comb
    begin
        logic       found;
        logic [4:0] cls;
        logic [4:0] kid;
        found    = 1'b0;
        cls      = CLS_NONE;
        kid      = '0;
        ctx_next = ctx;
        result   = '0;

        priority if (ctx.in_call)
        begin
            priority if (hits[P_OPEN])
                cls = CLS_PAREN;
            else if (hits[P_CLOSE])
            begin
                cls = CLS_CLOSE;
                ctx_next.in_call = 1'b0;
            end
            else
                cls = CLS_ARGWORD;
        end
        else if (hits[P_PRINTF])
        begin
            cls = CLS_PRINTF;
            ctx_next.in_call = 1'b1;
        end
        else if (hits[P_SCANF])
        begin
            cls = CLS_SCANF;
            ctx_next.in_call = 1'b1;
        end
        else if (is_kw_letter(first_char))
        begin
            for (int k = 0; k < NKW; k++)
            begin
                if (!found && hits[k])
                begin
                    found = 1'b1;
                    kid   = 5'(k);
                end
            end
            if (found)
            begin
                cls = CLS_KEYWORD;
                if (kw_type(kid) != TYPE_NONE)
                    ctx_next.pending_type = kw_type(kid);
            end
            else
                cls = CLS_IDENT;
        end
        else if (first_char == CH_LT || first_char == CH_GT ||
                 first_char == CH_EQ || first_char == CH_BANG)
        begin
            for (int k = 0; k < NRELOP; k++)
            begin
                if (!found && hits[P_RELOP + k])
                begin
                    found = 1'b1;
                    cls   = CLS_RELOP + 5'(k);
                end
            end
        end
        else if (first_char >= CH_ZERO && first_char <= CH_NINE)
        begin
            priority if ((number_flags & NF_OTHER) != '0)
                cls = CLS_DIGITVAR;
            else if ((number_flags & NF_DOT) != '0)
                cls = CLS_FLOAT;
            else
                cls = CLS_INT;
        end
        else if (first_char == CH_M)
        begin
            priority if (hits[P_MAIN_PAREN])
                cls = CLS_MAIN;
            else if (hits[P_MAIN])
                cls = CLS_NONE;
            else
                cls = CLS_IDENT;
        end
        else if (first_char == CH_PLUS || first_char == CH_MINUS ||
                 first_char == CH_STAR || first_char == CH_SLASH)
            cls = CLS_MATH;
        else if (first_char == CH_LBRACE || first_char == CH_LPAREN ||
                 first_char == CH_RPAREN || first_char == CH_RBRACE)
            cls = CLS_BRACE;
        else if (first_char == CH_SEMI)
            cls = CLS_SEMI;
        else
            cls = CLS_IDENT;

        result.token_class = cls;
        result.keyword_id  = (cls == CLS_KEYWORD) ? kid : 5'd0;
        if (cls == CLS_IDENT)
        begin
            result.declared_type  = ctx.pending_type;
            result.record_symbol  = (ctx.pending_type != TYPE_NONE);
            ctx_next.pending_type = TYPE_NONE;
        end
    end

endmodule

[rtl/c_token_classifier_top.sv]
// Top level of the C token classifier: input register, match, classify, result register.
// Result: a result word is registered from the input register that holds the last
//   character of a word, and is held back while out_stall holds a pending result.
// Throughput: one character word per cycle while out_stall does not hold a pending result;
//   the match vector and context update is combinational between the input and result registers.
// Reset: rst_n clears valids, match vector (all ones), position, first character, flags and context.
module c_token_classifier_top
    import c_tok_pkg::*;
#(
    parameter int MAX_WORD_LEN = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam int POS_W = $clog2(MAX_WORD_LEN + 1);

    logic             in_valid_reg;
    in_word_t         in_word_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic [NPAT-1:0]  match_vector_reg, match_vector_next;
    logic [POS_W-1:0] char_position_reg, char_position_next;
    logic [7:0]       first_char_reg, first_char_next;
    logic [2:0]       number_flags_reg, number_flags_next;
    ctx_t             ctx_reg, ctx_next;

    logic [NPAT-1:0]  hits;
    out_word_t        result;
    logic             advance;
    logic             fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    c_tok_match #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_match (
        .char_code          (in_word_reg.char_code),
        .match_vector       (match_vector_reg),
        .char_position      (char_position_reg),
        .first_char         (first_char_reg),
        .number_flags       (number_flags_reg),
        .match_vector_next  (match_vector_next),
        .hits               (hits),
        .char_position_next (char_position_next),
        .first_char_next    (first_char_next),
        .number_flags_next  (number_flags_next)
    );

    c_tok_classify u_classify (
        .hits         (hits),
        .first_char   (first_char_next),
        .number_flags (number_flags_next),
        .ctx          (ctx_reg),
        .result       (result),
        .ctx_next     (ctx_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire && in_word_reg.word_end;
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_word_reg.word_end)
            out_word_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_vector_reg  <= '1;
            char_position_reg <= '0;
            first_char_reg    <= '0;
            number_flags_reg  <= '0;
            ctx_reg           <= '0;
        end
        else if (fire)
        begin
            if (in_word_reg.word_end)
            begin
                match_vector_reg  <= '1;
                char_position_reg <= '0;
                first_char_reg    <= '0;
                number_flags_reg  <= '0;
                ctx_reg           <= ctx_next;
            end
            else
            begin
                match_vector_reg  <= match_vector_next;
                char_position_reg <= char_position_next;
                first_char_reg    <= first_char_next;
                number_flags_reg  <= number_flags_next;
            end
        end
    end

endmodule
